// File: hdl/slet_pkg.sv
// ----------------------------------------------------------------------------
// slet_pkg
// Shared types, codes and helpers of the scheduled light event table.
// ----------------------------------------------------------------------------
package slet_pkg;

	localparam int TABLE_SLOTS_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ON     = 2'd1;
	localparam logic [1:0] MODE_OFF    = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	localparam logic [3:0] RULE_SAT      = 4'd6;
	localparam logic [3:0] RULE_WEEKDAYS = 4'd7;
	localparam logic [3:0] RULE_WEEKEND  = 4'd8;
	localparam logic [3:0] RULE_EVERY    = 4'd9;

	localparam logic [2:0] DAY_SUN = 3'd0;
	localparam logic [2:0] DAY_MON = 3'd1;
	localparam logic [2:0] DAY_FRI = 3'd5;
	localparam logic [2:0] DAY_SAT = 3'd6;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_CMD    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ON,
		OP_OFF,
		OP_REMOVE
	} op_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_SCAN,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  light;
		logic [3:0]  rule;
		logic [10:0] minute;
		logic [2:0]  today;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic       status;
		logic [7:0] cmd_light;
		logic       turn_on;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0]  light;
		logic [3:0]  day;
		logic [10:0] minute;
		logic        act_on;
	} entry_t;

	// Does a stored day rule fire on the given weekday
	function automatic logic rule_covers(logic [3:0] rule, logic [2:0] day);
		logic hit;
		hit = 1'b0;
		if (rule == RULE_EVERY) begin
			hit = 1'b1;
		end else if (day <= DAY_SAT) begin
			case (rule) inside
				[4'd0:RULE_SAT]: hit = (rule[2:0] == day);
				RULE_WEEKEND:    hit = (day == DAY_SUN) || (day == DAY_SAT);
				RULE_WEEKDAYS:   hit = (day inside {[DAY_MON:DAY_FRI]});
				default:         hit = 1'b0;
			endcase
		end
		return hit;
	endfunction

endpackage

// File: hdl/slet_fifo.sv
// ----------------------------------------------------------------------------
// slet_fifo
// Small register queue with full/empty flags and a first-word read port.
// ----------------------------------------------------------------------------
module slet_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = slet_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = store_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wptr_q] <= wdata;
		end
	end

endmodule

// File: hdl/slet_front.sv
// ----------------------------------------------------------------------------
// slet_front
// Input side: decodes the mode of each item and queues it for the engine.
// ----------------------------------------------------------------------------
module slet_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [7:0]         light_id,
	input  logic [3:0]         day_rule,
	input  logic [10:0]        minute_of_day,
	input  logic [2:0]         today,
	output logic               cmd_valid,
	output slet_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);

	slet_pkg::cmd_t cmd_in;
	logic           cmd_empty;
	logic [$bits(slet_pkg::cmd_t)-1:0] cmd_raw;

	always_comb begin
		cmd_in.light  = light_id;
		cmd_in.rule   = day_rule;
		cmd_in.minute = minute_of_day;
		cmd_in.today  = today;
		case (mode)
			slet_pkg::MODE_TICK:   cmd_in.op = slet_pkg::OP_TICK;
			slet_pkg::MODE_ON:     cmd_in.op = slet_pkg::OP_ON;
			slet_pkg::MODE_OFF:    cmd_in.op = slet_pkg::OP_OFF;
			slet_pkg::MODE_REMOVE: cmd_in.op = slet_pkg::OP_REMOVE;
			default:               cmd_in.op = slet_pkg::OP_TICK;
		endcase
	end

	slet_fifo #(
		.W     ($bits(slet_pkg::cmd_t)),
		.DEPTH (slet_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (cmd_in),
		.full   (full),
		.rd     (cmd_pop),
		.rdata  (cmd_raw),
		.empty  (cmd_empty)
	);

	assign cmd       = slet_pkg::cmd_t'(cmd_raw);
	assign cmd_valid = !cmd_empty;

endmodule

// File: hdl/slet_engine.sv
// ----------------------------------------------------------------------------
// slet_engine
// Back side: owns the entry table, walks it one slot per cycle for insert,
// remove and tick items (ticks stall on a full result queue), pushing results.
// ----------------------------------------------------------------------------
module slet_engine #(
	parameter int TABLE_SLOTS = slet_pkg::TABLE_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  slet_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_push,
	output slet_pkg::res_t res_data,
	input  logic           res_ready
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	slet_pkg::eng_state_t state_q, state_d;
	slet_pkg::cmd_t       cmd_q;

	logic [CW-1:0]          rd_idx_q, rd_idx_d;
	logic [IW-1:0]          idx_s1, idx_d;
	logic                   vld_s1, vld_d;
	logic                   held_vld_q, held_vld_d;
	logic [7:0]             held_light_q, held_light_d;
	logic                   held_on_q, held_on_d;
	logic                   found_q, found_d;
	logic [TABLE_SLOTS-1:0] valid_q, valid_d;

	slet_pkg::entry_t mem [TABLE_SLOTS];
	slet_pkg::entry_t rdata_s1;
	slet_pkg::entry_t mem_wdata;
	logic             mem_we;
	logic [IW-1:0]    mem_raddr;
	logic             is_sched;
	logic             hit;
	logic             stall;
	logic             scan_end;

	assign is_sched  = (cmd_q.op == slet_pkg::OP_ON) || (cmd_q.op == slet_pkg::OP_OFF);
	assign scan_end  = (rd_idx_q == CW'(TABLE_SLOTS));

	always_comb begin
		mem_wdata.light  = cmd_q.light;
		mem_wdata.day    = cmd_q.rule;
		mem_wdata.minute = cmd_q.minute;
		mem_wdata.act_on = (cmd_q.op == slet_pkg::OP_ON);
	end

	always_comb begin
		state_d      = state_q;
		rd_idx_d     = rd_idx_q;
		idx_d        = idx_s1;
		vld_d        = vld_s1;
		held_vld_d   = held_vld_q;
		held_light_d = held_light_q;
		held_on_d    = held_on_q;
		found_d      = found_q;
		valid_d      = valid_q;
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		res_data     = '0;
		mem_we       = 1'b0;
		mem_raddr    = rd_idx_q[IW-1:0];
		hit          = 1'b0;
		stall        = 1'b0;

		case (state_q)
			slet_pkg::E_IDLE: begin
				if (cmd_valid) begin
					cmd_pop    = 1'b1;
					rd_idx_d   = '0;
					vld_d      = 1'b0;
					held_vld_d = 1'b0;
					found_d    = 1'b0;
					state_d    = slet_pkg::E_SCAN;
				end
			end
			slet_pkg::E_SCAN: begin
				if (is_sched) begin
					// lowest free slot wins; valid bits are flops, read without the memory port
					if (scan_end) begin
						state_d = slet_pkg::E_DONE;
					end else if (!valid_q[rd_idx_q[IW-1:0]]) begin
						mem_we                      = 1'b1;
						valid_d[rd_idx_q[IW-1:0]]   = 1'b1;
						found_d                     = 1'b1;
						state_d                     = slet_pkg::E_DONE;
					end else begin
						rd_idx_d = rd_idx_q + CW'(1);
					end
				end else begin
					if (vld_s1) begin
						if (cmd_q.op == slet_pkg::OP_TICK) begin
							hit = valid_q[idx_s1] &&
							      slet_pkg::rule_covers(rdata_s1.day, cmd_q.today) &&
							      (rdata_s1.minute == cmd_q.minute);
						end else begin
							hit = valid_q[idx_s1] &&
							      (rdata_s1.light == cmd_q.light) &&
							      (rdata_s1.day == cmd_q.rule) &&
							      (rdata_s1.minute == cmd_q.minute);
						end
						if (hit && cmd_q.op == slet_pkg::OP_TICK) begin
							// hold one match back so the final one can carry last
							if (held_vld_q && !res_ready) begin
								stall = 1'b1;
							end else begin
								if (held_vld_q) begin
									res_push           = 1'b1;
									res_data.kind      = slet_pkg::KIND_CMD;
									res_data.cmd_light = held_light_q;
									res_data.turn_on   = held_on_q;
								end
								held_vld_d   = 1'b1;
								held_light_d = rdata_s1.light;
								held_on_d    = rdata_s1.act_on;
							end
						end else if (hit) begin
							valid_d[idx_s1] = 1'b0;
						end
					end
					if (stall) begin
						// re-read the same slot while the result queue is full
						mem_raddr = idx_s1;
						vld_d     = 1'b1;
					end else if (!scan_end) begin
						idx_d    = rd_idx_q[IW-1:0];
						vld_d    = 1'b1;
						rd_idx_d = rd_idx_q + CW'(1);
					end else begin
						vld_d = 1'b0;
						if (!vld_s1) begin
							state_d = slet_pkg::E_DONE;
						end
					end
				end
			end
			slet_pkg::E_DONE: begin
				if (cmd_q.op == slet_pkg::OP_TICK) begin
					if (!held_vld_q) begin
						state_d = slet_pkg::E_IDLE;
					end else if (res_ready) begin
						res_push           = 1'b1;
						res_data.kind      = slet_pkg::KIND_CMD;
						res_data.cmd_light = held_light_q;
						res_data.turn_on   = held_on_q;
						res_data.last      = 1'b1;
						held_vld_d         = 1'b0;
						state_d            = slet_pkg::E_IDLE;
					end
				end else if (res_ready) begin
					res_push        = 1'b1;
					res_data.kind   = slet_pkg::KIND_STATUS;
					res_data.status = (is_sched && !found_q) ? slet_pkg::STATUS_FULL
					                                         : slet_pkg::STATUS_OK;
					res_data.last   = 1'b1;
					state_d         = slet_pkg::E_IDLE;
				end
			end
			default: begin
				state_d = slet_pkg::E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slet_pkg::E_IDLE;
			vld_s1     <= 1'b0;
			held_vld_q <= 1'b0;
			valid_q    <= '0;
		end else begin
			state_q    <= state_d;
			vld_s1     <= vld_d;
			held_vld_q <= held_vld_d;
			valid_q    <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q     <= rd_idx_d;
		idx_s1       <= idx_d;
		held_light_q <= held_light_d;
		held_on_q    <= held_on_d;
		found_q      <= found_d;
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	// entry table, single write port and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[rd_idx_q[IW-1:0]] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

endmodule

// File: hdl/scheduled_light_event_table.sv
// ----------------------------------------------------------------------------
// scheduled_light_event_table
// Table of scheduled light on/off events with tick-driven command output.
// ----------------------------------------------------------------------------
// Items enter a two-deep input queue and are carried out one at a time by an
// engine that walks the table a slot per cycle, remove and tick items through
// the entry memory's one registered read port; a tick match that waits on a
// full result queue holds the walk. Results leave through a two-deep result
// queue. A schedule item stops at the first free slot (or reports full after
// the last slot); a remove or tick item walks every slot. A tick gives one
// command per matching slot in slot order, the final one marked last; a tick
// with no match gives nothing. Valid marks are flip-flops cleared by reset, so
// the table is usable at once.
// ----------------------------------------------------------------------------
module scheduled_light_event_table #(
	parameter int TABLE_SLOTS = slet_pkg::TABLE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  light_id,
	input  logic [3:0]  day_rule,
	input  logic [10:0] minute_of_day,
	input  logic [2:0]  today,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic        status,
	output logic [7:0]  cmd_light,
	output logic        turn_on,
	output logic        last
);

	logic           cmd_valid;
	logic           cmd_pop;
	slet_pkg::cmd_t cmd;
	logic           res_push;
	logic           res_full;
	slet_pkg::res_t res_data;
	slet_pkg::res_t res_out;
	logic [$bits(slet_pkg::res_t)-1:0] res_raw;

	slet_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.light_id      (light_id),
		.day_rule      (day_rule),
		.minute_of_day (minute_of_day),
		.today         (today),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	slet_engine #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_ready (!res_full)
	);

	slet_fifo #(
		.W     ($bits(slet_pkg::res_t)),
		.DEPTH (slet_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.rd     (pop),
		.rdata  (res_raw),
		.empty  (empty)
	);

	assign res_out   = slet_pkg::res_t'(res_raw);
	assign kind      = res_out.kind;
	assign status    = res_out.status;
	assign cmd_light = res_out.cmd_light;
	assign turn_on   = res_out.turn_on;
	assign last      = res_out.last;

endmodule

// File: hdl/slet_checker.sv
// ----------------------------------------------------------------------------
// slet_checker
// Port-level checks of the scheduled light event table, bound to the top.
// ----------------------------------------------------------------------------
module slet_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic        status,
	input logic [7:0]  cmd_light,
	input logic        turn_on,
	input logic        last
);

	// status replies are single results with no light payload
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == slet_pkg::KIND_STATUS) |->
			(last && cmd_light == 8'd0 && !turn_on))
		else $error("status reply with light payload or without last");

	// a light command never reports table full
	a_cmd_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == slet_pkg::KIND_CMD) |-> (status == slet_pkg::STATUS_OK))
		else $error("light command carries table full");

	// a command not marked last must be followed by another command
	a_cmd_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && kind == slet_pkg::KIND_CMD && !last) |=>
			(empty || kind == slet_pkg::KIND_CMD))
		else $error("tick results interrupted by a status reply");

	// a waiting result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
			(!empty && $stable(kind) && $stable(status) && $stable(cmd_light) &&
			 $stable(turn_on) && $stable(last)))
		else $error("waiting result changed before it was taken");

endmodule

bind scheduled_light_event_table slet_checker u_slet_checker (.*);

// File: test/scheduled_light_event_table_tb.sv
// ----------------------------------------------------------------------------
// scheduled_light_event_table_tb
// Self-checking bench for the scheduled light event table.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the event table and predicts the status
// replies and light commands for every accepted item. Directed items cover
// rule and minute extremes, duplicates, removal and out-of-range fields.
// Random items then alternate between fill-heavy and drain-heavy stretches so
// the table regularly runs full and ticks hit several entries at once. Both
// handshakes idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module scheduled_light_event_table_tb;

	localparam int SLOTS          = slet_pkg::TABLE_SLOTS_DEF;
	localparam int RANDOM_ITEMS   = 290;
	localparam int CALM_ITEMS     = 40;
	localparam int PHASE_ITEMS    = 70;
	localparam int TAIL_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic [3:0]  RULE_SUN       = {1'b0, slet_pkg::DAY_SUN};
	localparam logic [3:0]  RULE_BAD_LO    = 4'd10;
	localparam logic [3:0]  RULE_BAD_HI    = 4'd15;
	localparam logic [2:0]  DAY_NONE       = 3'd7;
	localparam logic [10:0] MINUTE_NOON    = 11'd720;
	localparam logic [10:0] MINUTE_LAST    = 11'd1439;
	localparam logic [10:0] MINUTE_RAW_MAX = 11'h7FF;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  mode;
	logic [7:0]  light_id;
	logic [3:0]  day_rule;
	logic [10:0] minute_of_day;
	logic [2:0]  today;
	logic        empty;
	logic        pop;
	logic        kind;
	logic        status;
	logic [7:0]  cmd_light;
	logic        turn_on;
	logic        last;

	bit calm;
	int quiet_cycles = 0;

	class light_schedule_board;
		logic             slot_used [SLOTS];
		slet_pkg::entry_t slot_ent  [SLOTS];
		slet_pkg::res_t   due_q[$];
		int               errors;

		function new();
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			errors = 0;
		endfunction

		function bit day_fires(logic [3:0] rule, logic [2:0] day);
			case (rule)
				slet_pkg::RULE_EVERY:    return 1'b1;
				slet_pkg::RULE_WEEKDAYS:
					return day >= slet_pkg::DAY_MON && day <= slet_pkg::DAY_FRI;
				slet_pkg::RULE_WEEKEND:
					return day == slet_pkg::DAY_SUN || day == slet_pkg::DAY_SAT;
				default: return rule <= slet_pkg::RULE_SAT && rule[2:0] == day;
			endcase
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function int random_slot();
			int used[$];
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i])
					used.push_back(i);
			if (used.size() == 0)
				return -1;
			return used[$urandom_range(0, used.size() - 1)];
		endfunction

		function void note_item(slet_pkg::cmd_t c);
			slet_pkg::res_t r;
			int             slot;
			int             hits;
			r      = '0;
			r.kind = slet_pkg::KIND_STATUS;
			r.last = 1'b1;
			case (c.op)
				slet_pkg::OP_TICK: begin
					hits = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_used[i] && slot_ent[i].minute == c.minute &&
						    day_fires(slot_ent[i].day, c.today)) begin
							r.kind      = slet_pkg::KIND_CMD;
							r.cmd_light = slot_ent[i].light;
							r.turn_on   = slot_ent[i].act_on;
							r.last      = 1'b0;
							due_q.push_back(r);
							hits++;
						end
					end
					if (hits > 0) begin
						r      = due_q[due_q.size() - 1];
						r.last = 1'b1;
						due_q[due_q.size() - 1] = r;
					end
				end
				slet_pkg::OP_REMOVE: begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_used[i] && slot_ent[i].light == c.light &&
						    slot_ent[i].day == c.rule && slot_ent[i].minute == c.minute)
							slot_used[i] = 1'b0;
					r.status = slet_pkg::STATUS_OK;
					due_q.push_back(r);
				end
				default: begin
					slot = -1;
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!slot_used[i])
							slot = i;
					if (slot < 0) begin
						r.status = slet_pkg::STATUS_FULL;
					end else begin
						slot_used[slot]       = 1'b1;
						slot_ent[slot].light  = c.light;
						slot_ent[slot].day    = c.rule;
						slot_ent[slot].minute = c.minute;
						slot_ent[slot].act_on = (c.op == slet_pkg::OP_ON);
						r.status              = slet_pkg::STATUS_OK;
					end
					due_q.push_back(r);
				end
			endcase
		endfunction

		function void field_check(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(slet_pkg::res_t got);
			slet_pkg::res_t want;
			if (due_q.size() == 0) begin
				$display("%0t: expected no result, actual kind %0d status %0d", $time,
				         got.kind, got.status);
				$display("%0t:   actual light %0d on %0d last %0d", $time,
				         got.cmd_light, got.turn_on, got.last);
				errors++;
				return;
			end
			want = due_q.pop_front();
			field_check("kind", 8'(want.kind), 8'(got.kind));
			field_check("status", 8'(want.status), 8'(got.status));
			field_check("cmd_light", want.cmd_light, got.cmd_light);
			field_check("turn_on", 8'(want.turn_on), 8'(got.turn_on));
			field_check("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	light_schedule_board board;

	scheduled_light_event_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.light_id      (light_id),
		.day_rule      (day_rule),
		.minute_of_day (minute_of_day),
		.today         (today),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.status        (status),
		.cmd_light     (cmd_light),
		.turn_on       (turn_on),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Acceptance monitor, scoreboard hookup and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.note_item(slet_pkg::cmd_t'{slet_pkg::op_t'(mode), light_id,
				                                 day_rule, minute_of_day, today});
			if (pop && !empty)
				board.check_result(slet_pkg::res_t'{kind, status, cmd_light,
				                                    turn_on, last});
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	function automatic logic [10:0] pick_minute();
		case ($urandom_range(0, 5))
			0:       return 11'd0;
			1:       return MINUTE_LAST;
			2:       return MINUTE_NOON;
			3:       return MINUTE_NOON + 11'd1;
			4:       return 11'($urandom_range(0, 1439));
			default: return 11'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic slet_pkg::cmd_t random_item(bit filling);
		slet_pkg::cmd_t c;
		int             pick;
		int             slot;
		c.op     = slet_pkg::op_t'($urandom_range(0, 3));
		c.light  = 8'($urandom_range(0, 255));
		c.rule   = 4'($urandom_range(0, 15));
		c.minute = 11'($urandom_range(0, 2047));
		c.today  = 3'($urandom_range(0, 7));
		pick     = $urandom_range(0, 99);
		if (pick >= 95)
			return c;
		if (pick < (filling ? 60 : 15)) begin
			c.op = $urandom_range(0, 1) ? slet_pkg::OP_ON : slet_pkg::OP_OFF;
			// small id pool so duplicates and multi-hit ticks are common
			if ($urandom_range(0, 9) < 7)
				c.light = 8'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 9)
				c.rule = 4'($urandom_range(0, 9));
			c.minute = pick_minute();
		end else if (pick < (filling ? 85 : 50)) begin
			c.op = slet_pkg::OP_TICK;
			slot = board.random_slot();
			if (slot >= 0 && $urandom_range(0, 9) < 7)
				c.minute = board.slot_ent[slot].minute;
			else
				c.minute = pick_minute();
		end else begin
			c.op = slet_pkg::OP_REMOVE;
			slot = board.random_slot();
			if (slot >= 0) begin
				c.light  = board.slot_ent[slot].light;
				c.rule   = board.slot_ent[slot].day;
				c.minute = board.slot_ent[slot].minute;
			end
		end
		return c;
	endfunction

	task automatic send_item(slet_pkg::cmd_t c);
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push          <= 1'b1;
		mode          <= c.op;
		light_id      <= c.light;
		day_rule      <= c.rule;
		minute_of_day <= c.minute;
		today         <= c.today;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_all_results();
		push <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// Result side: random pop stalls
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		board         = new();
		calm          = 1'b0;
		arst_n        <= 1'b0;
		push          <= 1'b0;
		mode          <= slet_pkg::MODE_TICK;
		light_id      <= '0;
		day_rule      <= '0;
		minute_of_day <= '0;
		today         <= slet_pkg::DAY_SUN;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'd0, RULE_SUN, 11'd0,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_OFF, 8'd255, slet_pkg::RULE_EVERY,
		                           MINUTE_LAST, slet_pkg::DAY_SAT});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'h5A, slet_pkg::RULE_WEEKDAYS,
		                           MINUTE_NOON, DAY_NONE});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_OFF, 8'hA5, slet_pkg::RULE_WEEKEND,
		                           MINUTE_NOON, slet_pkg::DAY_MON});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'h33, RULE_BAD_HI, MINUTE_NOON,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'h33, RULE_BAD_LO, MINUTE_NOON,
		                           slet_pkg::DAY_SUN});
		// out-of-range minute, scheduled twice
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'h77, RULE_SUN, MINUTE_RAW_MAX,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'h77, RULE_SUN, MINUTE_RAW_MAX,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, 11'd0,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, MINUTE_NOON,
		                           slet_pkg::DAY_MON});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, MINUTE_NOON,
		                           slet_pkg::DAY_SAT});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, MINUTE_LAST, DAY_NONE});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, MINUTE_NOON, DAY_NONE});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'hFF, RULE_BAD_HI, MINUTE_RAW_MAX,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, 11'd5,
		                           slet_pkg::DAY_FRI});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_REMOVE, 8'h77, RULE_SUN, MINUTE_RAW_MAX,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, MINUTE_RAW_MAX,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_REMOVE, 8'd1, slet_pkg::RULE_EVERY, 11'd1,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_REMOVE, 8'h33, RULE_BAD_HI, MINUTE_NOON,
		                           DAY_NONE});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_ON, 8'hC3, slet_pkg::RULE_SAT, 11'd1000,
		                           slet_pkg::DAY_SUN});
		send_item(slet_pkg::cmd_t'{slet_pkg::OP_TICK, 8'd0, 4'd0, 11'd1000,
		                           slet_pkg::DAY_SAT});
		wait_all_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (n % 100 == 99)
				wait_all_results();
			send_item(random_item(((n / PHASE_ITEMS) % 2) == 0));
		end

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
